// ===== rtl/dtb100_pkg.sv =====
// shared types, constants and codes of the decimal text to base-100 parser
// used by dtb100_step, dtb100_outq and decimal_text_to_base100_parser
package dtb100_pkg;

	// default depth of the result queue, a power of two, at least 2
	localparam int DTB_OQ_DEPTH = 4;

	// register reset values
	localparam logic [8:0] MAX_MANT_RESET = 9'd511;
	localparam logic [9:0] MAX_EXP_RESET  = 10'd1023;

	// register index decoded from paddr[2]
	localparam logic REG_MAX_MANT = 1'b0;
	localparam logic REG_MAX_EXP  = 1'b1;

	// status codes of the summary
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_BADEXP  = 3'd4;
	localparam logic [2:0] ST_BADMANT = 3'd5;
	localparam logic [2:0] ERR_NONE   = 3'd0;

	// result kinds
	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_LO_E  = 8'h65;

	// mantissa exponent limits
	localparam logic signed [11:0] MEXP_FLOOR = -12'sd2048;
	localparam logic signed [11:0] MEXP_CEIL  = 12'sd2047;

	// parser phase, one-hot
	typedef enum logic [7:0] {
		PH_START  = 8'b0000_0001,
		PH_LEAD   = 8'b0000_0010,
		PH_SIGN   = 8'b0000_0100,
		PH_MANT   = 8'b0000_1000,
		PH_ESTART = 8'b0001_0000,
		PH_ESIGN  = 8'b0010_0000,
		PH_EDIG   = 8'b0100_0000,
		PH_TRAIL  = 8'b1000_0000
	} phase_t;

	// running state of one string
	typedef struct packed {
		phase_t             phase;
		logic               minus_seen;
		logic               point_seen;
		logic               sig_seen;
		logic [6:0]         pair_value;
		logic [1:0]         pair_digits;
		logic [9:0]         bytes_done;
		logic [9:0]         last_nonzero;
		logic signed [11:0] mant_exp;
		logic [13:0]        exp_value;
		logic               exp_minus;
		logic [2:0]         error_code;
	} run_t;

	localparam run_t RUN_CLEAR = '{
		phase: PH_START, minus_seen: 1'b0, point_seen: 1'b0, sig_seen: 1'b0,
		pair_value: 7'd0, pair_digits: 2'd0, bytes_done: 10'd0,
		last_nonzero: 10'd0, mant_exp: 12'sd0, exp_value: 14'd0,
		exp_minus: 1'b0, error_code: ERR_NONE
	};

	// one input item
	typedef struct packed {
		logic [7:0] character;
		logic       char_present;
		logic       last_char;
	} item_t;

	// one result item
	typedef struct packed {
		logic        kind;
		logic [8:0]  byte_index;
		logic [6:0]  digit_pair;
		logic        end_of_run;
		logic [2:0]  status;
		logic        negative;
		logic [10:0] exponent;
		logic [9:0]  mantissa_length;
	} result_t;

	// results of one item: an optional mantissa byte, then an optional summary
	typedef struct packed {
		logic    byte_v;
		result_t byte_r;
		logic    sum_v;
		result_t sum_r;
	} res_pair_t;

endpackage

// ===== rtl/decimal_text_to_base100_parser.sv =====
// top level of the decimal text to base-100 parser
// depends on dtb100_pkg, dtb100_step and dtb100_outq
//
// an accepted character is held in the input register and worked on once the queue has room;
// its results are then written into the result queue, whose non-empty state drives m_tvalid
// throughput: one character per cycle; an item causes at most two results and the single
// output port takes one per cycle, s_tready drops while fewer than two queue slots are free
// reset: arst_n clears the run state, the queue pointers and the input stage, and
// sets max_mantissa_bytes to 511 and max_exponent to 1023
module decimal_text_to_base100_parser import dtb100_pkg::*; #(
	parameter int OQ_DEPTH = DTB_OQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input characters
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tuser,   // [0] char_present
	input  logic        s_tlast,   // last_char
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	// [8:0] byte_index, [15:9] digit_pair, [18:16] status, [19] negative,
	// [30:20] exponent, [40:31] mantissa_length, [47:41] zero
	output logic [47:0] m_tdata,
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,   // end_of_run
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [8:0] max_mant_q;
	logic [9:0] max_exp_q;
	logic       cfg_wr;

	// input stage
	logic       valid_s1;
	item_t      item_s1;

	// run state and per-item results
	run_t       run_q;
	run_t       run_next;
	res_pair_t  res;
	res_pair_t  push;
	logic       room;
	logic       advance;
	result_t    head;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mant_q <= MAX_MANT_RESET;
			max_exp_q  <= MAX_EXP_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MAX_MANT: max_mant_q <= pwdata[8:0];
				REG_MAX_EXP:  max_exp_q  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_MANT: prdata = {23'd0, max_mant_q};
			REG_MAX_EXP:  prdata = {22'd0, max_exp_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	// the held item is worked on once the queue can take both of its results
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (s_tready) valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.character    <= s_tdata;
			item_s1.char_present <= s_tuser;
			item_s1.last_char    <= s_tlast;
		end
	end

	// ---------------- character step ----------------
	dtb100_step u_step (
		.st       (run_q),
		.item     (item_s1),
		.max_mant (max_mant_q),
		.max_exp  (max_exp_q),
		.ns       (run_next),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) run_q <= RUN_CLEAR;
		else if (advance) run_q <= run_next;
	end

	// results only enter the queue for a transaction being worked on
	always_comb begin
		push        = res;
		push.byte_v = res.byte_v && advance;
		push.sum_v  = res.sum_v && advance;
	end

	// ---------------- result queue ----------------
	dtb100_outq #(.DEPTH(OQ_DEPTH)) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.has_room  (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (head)
	);

	assign m_tdata = {7'd0, head.mantissa_length, head.exponent, head.negative,
		head.status, head.digit_pair, head.byte_index};
	assign m_tuser = head.kind;
	assign m_tlast = head.end_of_run;

	// ---------------- assertions ----------------
	// a finished string always leaves a summary waiting
	a_summary_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_char |=> m_tvalid)
		else $error("no result after end of string");

	// end of string returns the run to its start
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_char |=> run_q.phase == PH_START
			&& run_q.bytes_done == 10'd0 && run_q.error_code == ERR_NONE)
		else $error("run state not cleared after end of string");

	// once an error is latched no mantissa byte is produced
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && run_q.error_code != ERR_NONE |-> !res.byte_v)
		else $error("mantissa byte after error");

endmodule

// ===== rtl/dtb100_step.sv =====
// next-state and result logic for one character of the parser
// depends on dtb100_pkg
module dtb100_step import dtb100_pkg::*; (
	input  run_t       st,
	input  item_t      item,
	input  logic [8:0] max_mant,
	input  logic [9:0] max_exp,
	output run_t       ns,
	output res_pair_t  res
);

	always_comb begin
		logic [7:0]         c;
		logic [3:0]         d;
		logic               is_blank;
		logic               is_digit;
		logic               do_mant;
		logic               do_edig;
		logic [9:0]         prior_bytes;
		logic [16:0]        ev_next;
		logic [16:0]        ev_lim;
		logic signed [14:0] total;
		logic signed [14:0] lim;
		logic [6:0]         pad;

		c        = item.character;
		d        = c[3:0];
		is_blank = (c == CH_SPACE) || (c == CH_TAB);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		do_mant  = 1'b0;
		do_edig  = 1'b0;
		prior_bytes = '0;
		ev_next  = '0;
		ev_lim   = '0;
		total    = '0;
		lim      = '0;
		pad      = '0;
		ns       = st;
		res      = '0;

		if (item.char_present && st.error_code == ERR_NONE) begin
			unique case (st.phase)
				PH_START, PH_LEAD: begin
					if (is_blank) ns.phase = PH_LEAD;
					else if (c == CH_PLUS) ns.phase = PH_SIGN;
					else if (c == CH_MINUS) begin
						ns.minus_seen = 1'b1;
						ns.phase      = PH_SIGN;
					end else do_mant = 1'b1;
				end
				PH_SIGN: begin
					if (is_blank) ns.error_code = ST_INVALID;
					else do_mant = 1'b1;
				end
				PH_MANT: do_mant = 1'b1;
				PH_ESTART: begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						ns.exp_minus = (c == CH_MINUS);
						ns.phase     = PH_ESIGN;
					end else if (is_digit) do_edig = 1'b1;
					else ns.error_code = ST_INVALID;
				end
				PH_ESIGN: begin
					if (is_digit) do_edig = 1'b1;
					else ns.error_code = ST_INVALID;
				end
				PH_EDIG: begin
					if (is_digit) do_edig = 1'b1;
					else if (is_blank) ns.phase = PH_TRAIL;
					else ns.error_code = ST_INVALID;
				end
				PH_TRAIL: begin
					if (!is_blank) ns.error_code = ST_INVALID;
				end
				default: ns.phase = PH_START;
			endcase

			// mantissa character
			if (do_mant) begin
				ns.phase = PH_MANT;
				if (c == CH_UP_E || c == CH_LO_E) ns.phase = PH_ESTART;
				else if (c == CH_POINT) begin
					if (ns.point_seen) ns.error_code = ST_INVALID;
					else begin
						ns.point_seen = 1'b1;
						if (!ns.sig_seen) ns.mant_exp = -12'sd1;
					end
				end else if (is_digit) begin
					// the pair that this digit belongs to
					prior_bytes = ns.bytes_done;
					if (ns.pair_digits == 2'd0 && ns.bytes_done != 10'd0)
						prior_bytes = ns.bytes_done - 10'd1;
					if (!ns.sig_seen && !ns.point_seen && d == 4'd0) begin
						// leading zero before the point
					end else if (prior_bytes >= {1'b0, max_mant}) begin
						ns.error_code = ST_BADMANT;
					end else if (!ns.sig_seen && d == 4'd0) begin
						// zero after the point before the first significant digit
						if (ns.mant_exp != MEXP_FLOOR) ns.mant_exp = ns.mant_exp - 12'sd1;
					end else begin
						if (!ns.point_seen && ns.sig_seen && ns.mant_exp != MEXP_CEIL)
							ns.mant_exp = ns.mant_exp + 12'sd1;
						ns.sig_seen    = 1'b1;
						ns.pair_value  = {ns.pair_value[3:0], 3'b000}
							+ {ns.pair_value[5:0], 1'b0} + {3'b000, d};
						ns.pair_digits = ns.pair_digits + 2'd1;
						if (ns.pair_digits == 2'd2) begin
							res.byte_v            = 1'b1;
							res.byte_r.kind       = KIND_BYTE;
							res.byte_r.byte_index = ns.bytes_done[8:0];
							res.byte_r.digit_pair = ns.pair_value;
							if (ns.pair_value != 7'd0) ns.last_nonzero = ns.bytes_done + 10'd1;
							ns.bytes_done  = ns.bytes_done + 10'd1;
							ns.pair_value  = 7'd0;
							ns.pair_digits = 2'd0;
						end
					end
				end else if (is_blank) ns.phase = PH_TRAIL;
				else ns.error_code = ST_INVALID;
			end

			// exponent digit
			if (do_edig) begin
				ns.phase = PH_EDIG;
				ev_next  = {ns.exp_value, 3'b000} + {2'b00, ns.exp_value, 1'b0}
					+ {13'd0, d};
				ev_lim   = {4'd0, max_exp, 3'b000} + {6'd0, max_exp, 1'b0};
				if (ev_next > ev_lim) ns.error_code = ST_BADEXP;
				else ns.exp_value = ev_next[13:0];
			end
		end

		// end of string: summary, then back to a clear run
		if (item.last_char) begin
			res.sum_v          = 1'b1;
			res.sum_r.kind     = KIND_SUMMARY;
			res.sum_r.end_of_run = 1'b1;
			if (ns.error_code != ERR_NONE) res.sum_r.status = ns.error_code;
			else if (ns.phase == PH_START) res.sum_r.status = ST_EMPTY;
			else if (ns.phase == PH_LEAD || ns.phase == PH_SIGN
				|| ns.phase == PH_ESTART || ns.phase == PH_ESIGN)
				res.sum_r.status = ST_INVALID;
			else if (!ns.sig_seen) begin
				res.sum_r.status   = ST_ZERO;
				res.sum_r.negative = ns.minus_seen;
			end else begin
				// odd final digit gets a zero units digit
				if (ns.pair_digits != 2'd0) begin
					pad                   = {ns.pair_value[3:0], 3'b000}
						+ {ns.pair_value[5:0], 1'b0};
					res.byte_v            = 1'b1;
					res.byte_r.kind       = KIND_BYTE;
					res.byte_r.byte_index = ns.bytes_done[8:0];
					res.byte_r.digit_pair = pad;
					if (pad != 7'd0) ns.last_nonzero = ns.bytes_done + 10'd1;
				end
				lim = $signed({5'd0, max_exp});
				if (ns.exp_minus)
					total = $signed({{3{ns.mant_exp[11]}}, ns.mant_exp})
						- $signed({1'b0, ns.exp_value});
				else
					total = $signed({{3{ns.mant_exp[11]}}, ns.mant_exp})
						+ $signed({1'b0, ns.exp_value});
				if (ns.mant_exp == MEXP_FLOOR || total > lim || total < -lim)
					res.sum_r.status = ST_BADEXP;
				else begin
					res.sum_r.status          = ST_OK;
					res.sum_r.negative        = ns.minus_seen;
					res.sum_r.exponent        = total[10:0];
					res.sum_r.mantissa_length = ns.last_nonzero;
				end
			end
			ns = RUN_CLEAR;
		end
	end

endmodule

// ===== rtl/dtb100_outq.sv =====
// result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high
// depends on dtb100_pkg
module dtb100_outq import dtb100_pkg::*; #(
	parameter int DEPTH = DTB_OQ_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t push,
	output logic      has_room,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_data
);

	localparam int AW = $clog2(DEPTH);

	result_t        mem [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [AW:0]    count_q;
	logic [AW:0]    n_push;
	logic           pop;

	assign n_push    = (AW+1)'(push.byte_v) + (AW+1)'(push.sum_v);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	// room for the two results one item can cause
	assign has_room  = (count_q <= (AW+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.byte_v) mem[wptr_q] <= push.byte_r;
		if (push.sum_v) mem[wptr_q + AW'(push.byte_v)] <= push.sum_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + n_push[AW-1:0];
			if (pop) rptr_q <= rptr_q + AW'(1);
			count_q <= count_q + n_push - (AW+1)'(pop);
		end
	end

	assign out_data = mem[rptr_q];

endmodule

// ===== dv/decimal_text_to_base100_parser_tb.sv =====
// testbench of decimal_text_to_base100_parser: streams number strings through the slave side
// and checks every mantissa byte and summary against a built-in parser model
// depends on dtb100_pkg and the rtl of decimal_text_to_base100_parser
module decimal_text_to_base100_parser_tb;
	import dtb100_pkg::*;

	// register byte addresses, index taken from paddr[2]
	localparam logic [2:0] ADDR_MAX_MANT = {REG_MAX_MANT, 2'b00};
	localparam logic [2:0] ADDR_MAX_EXP  = {REG_MAX_EXP, 2'b00};
	// receiver hold-off length, and quiet cycles after the last result of a phase
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 4;
	// characters of random strings per phase
	localparam int RANDOM_CHARS = 42;
	// characters that steer the parser into its interesting branches
	localparam string ALPHA = "+-.eE \t0123456789x";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] character
	logic        s_tuser = 1'b0;   // [0] char_present
	logic        s_tlast = 1'b0;   // last_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [8:0] byte_index, [15:9] digit_pair, [18:16] status, [19] negative,
	// [30:20] exponent, [40:31] mantissa_length, [47:41] zero
	logic [47:0] m_tdata;
	logic        m_tuser;          // [0] kind
	logic        m_tlast;          // end_of_run
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	decimal_text_to_base100_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// characters waiting for the driver, results the parser still owes
	item_t   chars_to_send[$];
	result_t results_due[$];
	item_t   on_bus;

	// idling knobs, percent of cycles
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_arm = 1'b0;
	logic rx_hold = 1'b0;

	int fail_count = 0;
	int chars_accepted = 0;
	int strings_done = 0;
	int results_checked = 0;
	int n_settings = 1;

	// ---------------------------------------------------------------------
	// parser model: register copies and running state of one string
	// ---------------------------------------------------------------------
	logic [8:0]         lim_mant = MAX_MANT_RESET;
	logic [9:0]         lim_exp = MAX_EXP_RESET;
	phase_t             ph = PH_START;
	logic               minus_seen = 1'b0;
	logic               point_seen = 1'b0;
	logic               sig_seen = 1'b0;
	logic [6:0]         pair_val = 7'd0;
	logic [1:0]         pair_cnt = 2'd0;
	logic [9:0]         bytes_done = 10'd0;
	logic [9:0]         last_nz = 10'd0;
	logic signed [11:0] mexp = 12'sd0;
	logic [13:0]        exp_val = 14'd0;
	logic               exp_minus = 1'b0;
	logic [2:0]         err = ERR_NONE;

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	task automatic start_new_string();
		ph = PH_START;
		minus_seen = 1'b0;
		point_seen = 1'b0;
		sig_seen = 1'b0;
		pair_val = 7'd0;
		pair_cnt = 2'd0;
		bytes_done = 10'd0;
		last_nz = 10'd0;
		mexp = 12'sd0;
		exp_val = 14'd0;
		exp_minus = 1'b0;
		err = ERR_NONE;
	endtask

	task automatic emit_pair(input logic [6:0] v);
		result_t r;
		r = '0;
		r.kind = KIND_BYTE;
		r.byte_index = bytes_done[8:0];
		r.digit_pair = v;
		results_due.push_back(r);
		if (v != 7'd0)
			last_nz = bytes_done + 10'd1;
		bytes_done = bytes_done + 10'd1;
	endtask

	task automatic mant_digit(input int d);
		int prior_bytes;
		// index of the byte that the digit's pair would follow
		prior_bytes = int'(bytes_done);
		if (pair_cnt == 2'd0 && bytes_done != 10'd0)
			prior_bytes = int'(bytes_done) - 1;
		// leading zeros of the integer part are dropped silently
		if (!sig_seen && !point_seen && d == 0)
			return;
		if (prior_bytes >= int'(lim_mant)) begin
			err = ST_BADMANT;
			return;
		end
		// zeros between point and first significant digit lower the exponent
		if (!sig_seen && d == 0) begin
			if (mexp > MEXP_FLOOR)
				mexp--;
			return;
		end
		if (!point_seen && sig_seen && mexp < MEXP_CEIL)
			mexp++;
		sig_seen = 1'b1;
		pair_val = 7'(int'(pair_val) * 10 + d);
		pair_cnt++;
		if (pair_cnt >= 2'd2) begin
			emit_pair(pair_val);
			pair_val = 7'd0;
			pair_cnt = 2'd0;
		end
	endtask

	task automatic mant_char(input logic [7:0] c);
		ph = PH_MANT;
		if (c == CH_UP_E || c == CH_LO_E) begin
			ph = PH_ESTART;
		end else if (c == CH_POINT) begin
			if (point_seen) begin
				err = ST_INVALID;
			end else begin
				point_seen = 1'b1;
				if (!sig_seen)
					mexp = -12'sd1;
			end
		end else if (is_digit(c)) begin
			mant_digit(int'(c - CH_ZERO));
		end else if (is_blank(c)) begin
			ph = PH_TRAIL;
		end else begin
			err = ST_INVALID;
		end
	endtask

	task automatic exp_digit(input int d);
		int v;
		v = int'(exp_val) * 10 + d;
		ph = PH_EDIG;
		if (v > int'(lim_exp) * 10)
			err = ST_BADEXP;
		else
			exp_val = 14'(v);
	endtask

	task automatic feed_char(input logic [7:0] c);
		case (ph)
			PH_START, PH_LEAD: begin
				if (is_blank(c)) begin
					ph = PH_LEAD;
				end else if (c == CH_PLUS) begin
					ph = PH_SIGN;
				end else if (c == CH_MINUS) begin
					minus_seen = 1'b1;
					ph = PH_SIGN;
				end else begin
					mant_char(c);
				end
			end
			PH_SIGN: begin
				if (is_blank(c))
					err = ST_INVALID;
				else
					mant_char(c);
			end
			PH_MANT: begin
				mant_char(c);
			end
			PH_ESTART: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					exp_minus = (c == CH_MINUS);
					ph = PH_ESIGN;
				end else if (is_digit(c)) begin
					exp_digit(int'(c - CH_ZERO));
				end else begin
					err = ST_INVALID;
				end
			end
			PH_ESIGN: begin
				if (is_digit(c))
					exp_digit(int'(c - CH_ZERO));
				else
					err = ST_INVALID;
			end
			PH_EDIG: begin
				if (is_digit(c))
					exp_digit(int'(c - CH_ZERO));
				else if (is_blank(c))
					ph = PH_TRAIL;
				else
					err = ST_INVALID;
			end
			default: begin
				if (!is_blank(c))
					err = ST_INVALID;
			end
		endcase
	endtask

	task automatic close_string();
		result_t r;
		int total;
		int lim;
		r = '0;
		r.kind = KIND_SUMMARY;
		r.end_of_run = 1'b1;
		lim = int'(lim_exp);
		if (err != ERR_NONE) begin
			r.status = err;
		end else if (ph == PH_START) begin
			r.status = ST_EMPTY;
		end else if (ph == PH_LEAD || ph == PH_SIGN || ph == PH_ESTART || ph == PH_ESIGN) begin
			r.status = ST_INVALID;
		end else if (!sig_seen) begin
			r.status = ST_ZERO;
			r.negative = minus_seen;
		end else begin
			// odd final digit goes out padded before the exponent is judged
			if (pair_cnt != 2'd0)
				emit_pair(pair_val * 7'd10);
			total = int'(mexp);
			if (exp_minus)
				total -= int'(exp_val);
			else
				total += int'(exp_val);
			if (mexp <= MEXP_FLOOR || total > lim || total < -lim) begin
				r.status = ST_BADEXP;
			end else begin
				r.status = ST_OK;
				r.negative = minus_seen;
				r.exponent = total[10:0];
				r.mantissa_length = last_nz;
			end
		end
		results_due.push_back(r);
	endtask

	// what one accepted character transaction makes the parser produce
	task automatic parse_char_item(input item_t it);
		if (it.char_present && err == ERR_NONE)
			feed_char(it.character);
		if (it.last_char) begin
			close_string();
			start_new_string();
		end
	endtask

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------
	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [7:0] digit_char();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] blank_char();
		return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
	endfunction

	function automatic logic [7:0] any_char();
		logic [7:0] c;
		if ($urandom_range(0, 1) != 0)
			c = 8'($urandom_range(0, 255));
		else
			c = ALPHA[$urandom_range(0, ALPHA.len() - 1)];
		return c;
	endfunction

	task automatic send_item(input logic [7:0] ch, input logic present, input logic last);
		item_t it;
		it.character = ch;
		it.char_present = present;
		it.last_char = last;
		chars_to_send.push_back(it);
	endtask

	// a whole string; an empty one is a single item without character
	task automatic push_text(input string s);
		if (s.len() == 0) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else begin
			for (int i = 0; i < s.len(); i++)
				send_item(s[i], 1'b1, i == s.len() - 1);
		end
	endtask

	task automatic send_run(input logic [7:0] ch, input int count);
		repeat (count) send_item(ch, 1'b1, 1'b0);
	endtask

	// mostly well-formed numbers with random content, some noise and damage
	task automatic add_random_string(output int n_chars);
		logic [7:0] txt[$];
		int shape;
		int nint;
		int nfrac;
		bit tail_empty;
		shape = $urandom_range(0, 99);
		n_chars = 0;
		if (shape < 12) begin
			repeat ($urandom_range(1, 6)) txt.push_back(any_char());
		end else if (shape >= 16) begin
			repeat ($urandom_range(0, 2)) txt.push_back(blank_char());
			case ($urandom_range(0, 2))
				1: txt.push_back(CH_PLUS);
				2: txt.push_back(CH_MINUS);
				default: ;
			endcase
			repeat ($urandom_range(0, 2)) txt.push_back(CH_ZERO);
			nint = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
			repeat (nint) txt.push_back(digit_char());
			if ($urandom_range(0, 1) != 0) begin
				txt.push_back(CH_POINT);
				repeat ($urandom_range(0, 3)) txt.push_back(CH_ZERO);
				nfrac = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
				repeat (nfrac) txt.push_back(digit_char());
			end
			if ($urandom_range(0, 2) == 0) begin
				txt.push_back(($urandom_range(0, 1) != 0) ? CH_UP_E : CH_LO_E);
				case ($urandom_range(0, 2))
					1: txt.push_back(CH_PLUS);
					2: txt.push_back(CH_MINUS);
					default: ;
				endcase
				repeat ($urandom_range(0, 4)) txt.push_back(digit_char());
			end
			repeat ($urandom_range(0, 2)) txt.push_back(blank_char());
			if ($urandom_range(0, 9) == 0 && txt.size() != 0)
				txt[$urandom_range(0, txt.size() - 1)] = any_char();
		end
		if (txt.size() == 0) begin
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			return;
		end
		// the string may close on an item that carries no character
		tail_empty = ($urandom_range(0, 9) == 0);
		foreach (txt[i]) begin
			if ($urandom_range(0, 24) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(txt[i], 1'b1, !tail_empty && i == txt.size() - 1);
		end
		if (tail_empty)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		n_chars = txt.size();
	endtask

	task automatic random_phase(input int target);
		int n;
		int total;
		total = 0;
		while (total < target) begin
			add_random_string(n);
			total += n;
		end
	endtask

	// waits until the sender is done and all owed results are back, then for DRAIN_CYCLES more
	task automatic wait_drained();
		@(negedge clk);
		while (chars_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		// access phase ends here; write lands, read data is sampled
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// write both limits with junk in the unused bits, then read them back
	task automatic set_limits(input logic [8:0] mant, input logic [9:0] ex);
		logic [31:0] wd;
		logic [31:0] rd;
		wd = $urandom();
		wd[8:0] = mant;
		apb_xfer(1'b1, ADDR_MAX_MANT, wd, rd);
		wd = $urandom();
		wd[9:0] = ex;
		apb_xfer(1'b1, ADDR_MAX_EXP, wd, rd);
		lim_mant = mant;
		lim_exp = ex;
		apb_xfer(1'b0, ADDR_MAX_MANT, 32'd0, rd);
		if (rd[8:0] !== mant) begin
			$error("max_mantissa_bytes: expected %0d, got %0d", mant, rd[8:0]);
			fail_count++;
		end
		apb_xfer(1'b0, ADDR_MAX_EXP, 32'd0, rd);
		if (rd[9:0] !== ex) begin
			$error("max_exponent: expected %0d, got %0d", ex, rd[9:0]);
			fail_count++;
		end
		n_settings++;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// ---------------------------------------------------------------------
	// driver: presents queued characters, predicts at each accepted transaction
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : driver
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_char_item(on_bus);
				chars_accepted++;
				if (on_bus.last_char)
					strings_done++;
			end
			// a held transaction stays on the bus until taken
			if (!s_tvalid || s_tready) begin
				if (chars_to_send.size() != 0 && !chance(tx_idle_pct)) begin
					on_bus = chars_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= on_bus.character;
					s_tuser <= on_bus.char_present;
					s_tlast <= on_bus.last_char;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// monitor: compares each result transaction with the oldest one owed
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.byte_index = m_tdata[8:0];
				got.digit_pair = m_tdata[15:9];
				got.end_of_run = m_tlast;
				got.status = m_tdata[18:16];
				got.negative = m_tdata[19];
				got.exponent = m_tdata[30:20];
				got.mantissa_length = m_tdata[40:31];
				if (results_due.size() == 0) begin
					$error("result with nothing owed: kind %0d tdata 'h%h", got.kind, m_tdata);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", 32'(want.kind), 32'(got.kind));
					check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
					check_field("digit_pair", 32'(want.digit_pair), 32'(got.digit_pair));
					check_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("negative", 32'(want.negative), 32'(got.negative));
					check_field("exponent", 32'(want.exponent), 32'(got.exponent));
					check_field("mantissa_length", 32'(want.mantissa_length),
						32'(got.mantissa_length));
					results_checked++;
				end
			end
			m_tready <= !rx_hold && !chance(rx_stall_pct);
		end
	end

	// one long receiver hold-off so the result queue fills and s_tready drops
	initial begin : rx_hold_off
		wait (hold_arm);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : watchdog
		#400000;
		$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// phases: register setting, idling pattern, strings
	// ---------------------------------------------------------------------
	initial begin : stimulus
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limits, no idling: directed strings first
		push_text("");
		push_text("0");
		push_text("-0.00");
		push_text(".");
		push_text("0E5");
		push_text("E5");
		push_text(" \t ");
		push_text("+");
		push_text("-");
		push_text("1E");
		push_text("1e+");
		push_text("12.5e-3");
		push_text("\t-007.250E+12  ");
		push_text("1 2");
		push_text("1.2.3");
		push_text("x123");
		push_text("- 5");
		push_text("99");
		push_text("100");
		push_text("0.000123");
		push_text("1e99999");
		push_text("12345E1020");
		push_text("9E-1023");
		push_text("+1E1023");
		// characterless items inside a string and as its final item
		send_run("1", 1);
		send_item(8'hFF, 1'b0, 1'b0);
		push_text("2");
		send_run("5", 1);
		send_item(8'h00, 1'b0, 1'b1);
		random_phase(RANDOM_CHARS);
		wait_drained();

		// small limits, sender idling
		set_limits(9'd3, 10'd5);
		tx_idle_pct = 49;
		// longest mantissa that fits, then one digit more; exponent at and past its limit
		push_text("1234567");
		push_text("12345678");
		push_text("12E5");
		push_text("1E51");
		random_phase(RANDOM_CHARS);
		wait_drained();

		// limits of one, receiver stalling
		set_limits(9'd1, 10'd1);
		tx_idle_pct = 0;
		rx_stall_pct = 49;
		random_phase(RANDOM_CHARS);
		wait_drained();

		// full-scale limits, both sides idling, with the long hold-off
		set_limits(9'd511, 10'd1023);
		tx_idle_pct = 27;
		rx_stall_pct = 27;
		hold_arm = 1'b1;
		random_phase(RANDOM_CHARS);
		wait_drained();

		// limits at zero, no idling
		set_limits(9'd0, 10'd0);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		push_text("0.5");
		push_text("00");
		push_text("0E0");
		push_text("5");
		random_phase(RANDOM_CHARS);
		wait_drained();

		// mid-range random limits, both sides idling
		set_limits(9'($urandom_range(2, 12)), 10'($urandom_range(2, 40)));
		tx_idle_pct = 27;
		rx_stall_pct = 27;
		random_phase(RANDOM_CHARS);
		wait_drained();

		$display("parsed %0d character transactions in %0d strings, %0d results checked",
			chars_accepted, strings_done, results_checked);
		$display("limits used: %0d settings, from zero to full scale, under four idling patterns",
			n_settings);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
